FILE: rtl/autoranging_resistance_meter_assert.svh
// Assertion macros for the checker of the resistance meter.
`ifndef AUTORANGING_RESISTANCE_METER_ASSERT_SVH
`define AUTORANGING_RESISTANCE_METER_ASSERT_SVH

// Check on every rising edge of clk, skip while rst is high.
`define ARM_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Check on every rising edge of clk, reset included.
`define ARM_ASSERT_ANY(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: rtl/arm_pkg.sv
`timescale 1ns / 1ps

package arm_pkg;

  // Window length in ticks, and the tick counter that spans it
  localparam int WINDOW_TICKS = 256;
  localparam int TICK_W       = (WINDOW_TICKS > 2) ? $clog2(WINDOW_TICKS) : 1;

  // Field and state widths
  localparam int SAMPLE_W = 12;
  localparam int CODE_W   = 8;
  localparam int SUM_W    = 20;
  localparam int CNT_W    = 9;
  localparam int OHMS_W   = 16;
  localparam int SCALE_W  = 32;
  localparam int RES_W    = 23;
  localparam int FRAC_W   = 16;

  // Shared unit: shift word, adder and step counter
  localparam int LO_W   = SUM_W + SCALE_W - FRAC_W;
  localparam int ADD_W  = SCALE_W + 1;
  localparam int STEP_W = $clog2(LO_W + 1);

  localparam logic [STEP_W-1:0] QUO_STEPS = STEP_W'(SAMPLE_W);
  localparam logic [STEP_W-1:0] MUL_STEPS = STEP_W'(SUM_W);
  localparam logic [STEP_W-1:0] RES_STEPS = STEP_W'(LO_W);

  // Saturation limits
  localparam logic [CODE_W-1:0] CODE_MAX  = '1;
  localparam logic [SUM_W-1:0]  SUM_MAX   = '1;
  localparam logic [CNT_W-1:0]  CNT_MAX   = '1;
  localparam logic [RES_W-1:0]  RES_MAX   = RES_W'(4194303);
  localparam logic [RES_W-1:0]  QUO_CLAMP = RES_W'(4259838);

  // APB register map
  localparam int ADDR_W = 4;
  localparam int DATA_W = 32;
  localparam logic [1:0] REG_HIGH_LIMIT = 2'd0;
  localparam logic [1:0] REG_LOW_LIMIT  = 2'd1;
  localparam logic [1:0] REG_OFFSET     = 2'd2;
  localparam logic [1:0] REG_SCALE      = 2'd3;

  localparam logic [SAMPLE_W-1:0] HIGH_LIMIT_RST = SAMPLE_W'(4095);
  localparam logic [SAMPLE_W-1:0] LOW_LIMIT_RST  = SAMPLE_W'(1599);
  localparam logic [OHMS_W-1:0]   OFFSET_RST     = OHMS_W'(200);
  localparam logic [SCALE_W-1:0]  SCALE_RST      = SCALE_W'(27313334);

  typedef enum logic [1:0] {
    ST_VALID = 2'd0,
    ST_OVER  = 2'd1,
    ST_UNDER = 2'd2
  } status_t;

  typedef enum logic {
    OP_MUL = 1'b0,
    OP_DIV = 1'b1
  } mdu_op_t;

  typedef struct packed {
    logic              start;
    mdu_op_t           op;
    logic [STEP_W-1:0] steps;
  } mdu_cmd_t;

  typedef struct packed {
    logic busy;
    logic done;
  } mdu_stat_t;

endpackage

FILE: rtl/arm_mdu.sv
`timescale 1ns / 1ps

// Shift-add multiplier and restoring divider on one adder, one bit a cycle.
module arm_mdu import arm_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  mdu_cmd_t           cmd,
  input  logic [LO_W-1:0]    a,
  input  logic [SCALE_W-1:0] b,
  output mdu_stat_t          stat,
  output logic [LO_W-1:0]    result
);

  logic [SCALE_W-1:0] hi;
  logic [LO_W-1:0]    lo;
  logic [SCALE_W-1:0] opnd;
  mdu_op_t            op;
  logic [STEP_W-1:0]  cnt;
  logic               busy;
  logic               done;

  logic               sub;
  logic [CNT_W:0]     rsh;
  logic [ADD_W-1:0]   x;
  logic [ADD_W-1:0]   y;
  logic [ADD_W-1:0]   sum;
  logic               fits;

  // Divide: partial remainder with the next dividend bit; multiply: high half
  assign sub  = (op == OP_DIV);
  assign rsh  = {hi[CNT_W-1:0], lo[LO_W-1]};
  assign x    = sub ? ADD_W'(rsh) : {1'b0, hi};
  assign y    = sub ? ADD_W'(opnd[CNT_W-1:0]) : (lo[0] ? {1'b0, opnd} : '0);
  assign sum  = x + (sub ? ~y : y) + ADD_W'(sub);
  assign fits = ~sum[ADD_W-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (cmd.start) begin
        busy <= 1'b1;
        cnt  <= cmd.steps;
      end else if (busy) begin
        cnt <= cnt - STEP_W'(1);
        if (cnt == STEP_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      op   <= cmd.op;
      opnd <= b;
      hi   <= '0;
      lo   <= a;
    end else if (busy) begin
      if (sub) begin
        // keep the difference when it does not go negative
        hi <= fits ? SCALE_W'(sum[CNT_W-1:0]) : SCALE_W'(rsh[CNT_W-1:0]);
        lo <= {lo[LO_W-2:0], fits};
      end else begin
        hi <= sum[ADD_W-1:1];
        lo <= {sum[0], lo[LO_W-1:1]};
      end
    end
  end

  // Product drops its low fraction bits; quotient sits in the shift word
  assign result = (op == OP_MUL) ? {hi, lo[LO_W-1 -: LO_W-SCALE_W]} : lo;

  assign stat.busy = busy;
  assign stat.done = done;

endmodule

FILE: rtl/autoranging_resistance_meter.sv
`timescale 1ns / 1ps

// Autoranging resistance meter.
// Input channel: one adc_sample word per timer tick on in_valid/in_ready.
// Output channel: exactly one word per tick on out_valid/out_ready carrying
// current_code (drive to apply next tick), window_done, status and resistance.
// Registers high_limit, low_limit, offset_ohms and scale_q16 sit on the APB
// port at byte offsets 0x0, 0x4, 0x8, 0xC; write them only while idle.
// One tick at a time: in_ready drops on accept and rises when the word has
// moved to the output register. An over- or under-range tick skips the
// multiply/divide unit; an in-range tick runs the 12-step sample/code
// division; the in-range tick that closes a window adds the 20-step product
// of sum and scale and the 36-step division by the count.
// All of it runs on one shared one-bit-per-cycle multiply/divide unit.
// A stalled receiver holds the finished word in the output register; the
// next word is accepted meanwhile and waits in the last state until the
// register frees up.
// Reset (rst, synchronous) restores register defaults, sets the drive code
// to 255 and clears the tick, sum and count of the window.
module autoranging_resistance_meter import arm_pkg::*; (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     psel,
  input  logic                     penable,
  input  logic                     pwrite,
  input  logic [ADDR_W-1:0]        paddr,
  input  logic [DATA_W-1:0]        pwdata,
  output logic [DATA_W-1:0]        prdata,
  output logic                     pready,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic [SAMPLE_W-1:0]      adc_sample,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic [CODE_W-1:0]        current_code,
  output logic                     window_done,
  output logic [1:0]               status,
  output logic signed [RES_W-1:0]  resistance
);

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_QUO  = 5'b00010,
    S_MUL  = 5'b00100,
    S_RES  = 5'b01000,
    S_DONE = 5'b10000
  } state_t;

  state_t state;
  state_t state_next;

  // Configuration
  logic [SAMPLE_W-1:0] high_limit;
  logic [SAMPLE_W-1:0] low_limit;
  logic [OHMS_W-1:0]   offset_ohms;
  logic [SCALE_W-1:0]  scale_q16;

  // Window state
  logic [CODE_W-1:0]   drive_code;
  logic [TICK_W-1:0]   tick_count;
  logic [SUM_W-1:0]    quotient_sum;
  logic [CNT_W-1:0]    valid_count;

  // Per-tick working registers
  status_t             tick_status;
  logic                tick_last;
  logic [RES_W-1:0]    ohms;

  logic                in_fire;
  logic                cfg_write;
  logic                over;
  logic                under;
  status_t             cls;
  logic                emit;

  logic [CODE_W-1:0]   div_code;
  logic [SUM_W:0]      sum_wide;
  logic [SUM_W-1:0]    quotient_sum_next;
  logic [CNT_W-1:0]    valid_count_next;

  logic [RES_W-1:0]    quo_clamped;
  logic [RES_W:0]      diff;
  logic [RES_W-1:0]    ohms_next;

  mdu_cmd_t            mdu_cmd;
  mdu_stat_t           mdu_stat;
  logic [LO_W-1:0]     mdu_a;
  logic [SCALE_W-1:0]  mdu_b;
  logic [LO_W-1:0]     mdu_result;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite;
  assign in_ready  = (state == S_IDLE);
  assign in_fire   = in_valid && in_ready;

  // Over-range wins where the limits overlap
  assign over  = (adc_sample >= high_limit);
  assign under = (adc_sample <= low_limit);
  assign cls   = over ? ST_OVER : (under ? ST_UNDER : ST_VALID);

  // A zero code divides as one
  assign div_code = (drive_code == '0) ? CODE_W'(1) : drive_code;

  // Accumulate the sample quotient, saturating sum and count
  assign sum_wide          = {1'b0, quotient_sum} + (SUM_W+1)'(mdu_result[SAMPLE_W-1:0]);
  assign quotient_sum_next = sum_wide[SUM_W] ? SUM_MAX : sum_wide[SUM_W-1:0];
  assign valid_count_next  = (valid_count == CNT_MAX) ? valid_count
                                                      : valid_count + CNT_W'(1);

  // Clamp the averaged value, take off the offset, saturate on top
  assign quo_clamped = (mdu_result > LO_W'(QUO_CLAMP)) ? QUO_CLAMP
                                                       : mdu_result[RES_W-1:0];
  assign diff        = {1'b0, quo_clamped} - (RES_W+1)'(offset_ohms);
  assign ohms_next   = ($signed(diff) > $signed({1'b0, RES_MAX})) ? RES_MAX
                                                                 : diff[RES_W-1:0];

  assign emit = (state == S_DONE) && (!out_valid || out_ready);

  // Sequencer
  always_comb begin
    state_next    = state;
    mdu_cmd.start = 1'b0;
    mdu_cmd.op    = OP_DIV;
    mdu_cmd.steps = QUO_STEPS;
    mdu_a         = {adc_sample, {(LO_W-SAMPLE_W){1'b0}}};
    mdu_b         = SCALE_W'(div_code);
    unique case (state)
      S_IDLE: begin
        if (in_fire) begin
          if (cls == ST_VALID) begin
            mdu_cmd.start = 1'b1;
            state_next    = S_QUO;
          end else begin
            state_next = S_DONE;
          end
        end
      end
      S_QUO: begin
        if (mdu_stat.done) begin
          if (tick_last) begin
            mdu_cmd.start = 1'b1;
            mdu_cmd.op    = OP_MUL;
            mdu_cmd.steps = MUL_STEPS;
            mdu_a         = LO_W'(quotient_sum_next);
            mdu_b         = scale_q16;
            state_next    = S_MUL;
          end else begin
            state_next = S_DONE;
          end
        end
      end
      S_MUL: begin
        if (mdu_stat.done) begin
          mdu_cmd.start = 1'b1;
          mdu_cmd.steps = RES_STEPS;
          mdu_a         = mdu_result;
          mdu_b         = SCALE_W'(valid_count);
          state_next    = S_RES;
        end
      end
      S_RES: begin
        if (mdu_stat.done) begin
          state_next = S_DONE;
        end
      end
      S_DONE: begin
        if (emit) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  arm_mdu u_mdu (
    .clk    (clk),
    .rst    (rst),
    .cmd    (mdu_cmd),
    .a      (mdu_a),
    .b      (mdu_b),
    .stat   (mdu_stat),
    .result (mdu_result)
  );

  // Control and window state
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      out_valid    <= 1'b0;
      high_limit   <= HIGH_LIMIT_RST;
      low_limit    <= LOW_LIMIT_RST;
      offset_ohms  <= OFFSET_RST;
      scale_q16    <= SCALE_RST;
      drive_code   <= CODE_MAX;
      tick_count   <= '0;
      quotient_sum <= '0;
      valid_count  <= '0;
    end else begin
      state <= state_next;

      if (cfg_write) begin
        unique case (paddr[3:2])
          REG_HIGH_LIMIT: high_limit  <= pwdata[SAMPLE_W-1:0];
          REG_LOW_LIMIT:  low_limit   <= pwdata[SAMPLE_W-1:0];
          REG_OFFSET:     offset_ohms <= pwdata[OHMS_W-1:0];
          REG_SCALE:      scale_q16   <= pwdata[SCALE_W-1:0];
          default: begin
          end
        endcase
      end

      // Step the drive down on over-range, hold at one
      if (in_fire && over) begin
        drive_code <= (drive_code > CODE_W'(1)) ? drive_code - CODE_W'(1) : CODE_W'(1);
      end

      if ((state == S_QUO) && mdu_stat.done) begin
        quotient_sum <= quotient_sum_next;
        valid_count  <= valid_count_next;
      end

      if (emit) begin
        out_valid <= 1'b1;
        // Window end re-arms the drive and clears the window
        if (tick_last) begin
          drive_code   <= CODE_MAX;
          tick_count   <= '0;
          quotient_sum <= '0;
          valid_count  <= '0;
        end else begin
          tick_count <= tick_count + TICK_W'(1);
        end
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Payload
  always_ff @(posedge clk) begin
    if (in_fire) begin
      tick_status <= cls;
      tick_last   <= (tick_count == TICK_W'(WINDOW_TICKS - 1));
      ohms        <= '0;
    end else if ((state == S_RES) && mdu_stat.done) begin
      ohms <= ohms_next;
    end
    if (emit) begin
      current_code <= tick_last ? CODE_MAX : drive_code;
      window_done  <= tick_last;
      status       <= tick_status;
      resistance   <= $signed(ohms);
    end
  end

  // Register readback
  always_comb begin
    unique case (paddr[3:2])
      REG_HIGH_LIMIT: prdata = DATA_W'(high_limit);
      REG_LOW_LIMIT:  prdata = DATA_W'(low_limit);
      REG_OFFSET:     prdata = DATA_W'(offset_ohms);
      REG_SCALE:      prdata = DATA_W'(scale_q16);
      default:        prdata = '0;
    endcase
  end

endmodule

FILE: rtl/arm_checker.sv
`timescale 1ns / 1ps
`include "autoranging_resistance_meter_assert.svh"

module arm_checker import arm_pkg::*; (
  input logic                    clk,
  input logic                    rst,
  input logic                    in_valid,
  input logic                    in_ready,
  input logic                    out_valid,
  input logic                    out_ready,
  input logic [CODE_W-1:0]       current_code,
  input logic                    window_done,
  input logic [1:0]              status,
  input logic signed [RES_W-1:0] resistance
);

  // A stalled result word must stay put
  `ARM_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid && $stable(resistance) && $stable(current_code), "result word changed while stalled")

  // One tick in flight: ready drops right after an accept
  `ARM_ASSERT(a_one_tick, in_valid && in_ready |=> !in_ready, "second word accepted while busy")

  // Resistance reads zero unless a valid tick closes the window
  `ARM_ASSERT(a_res_zero, out_valid && !(window_done && status == ST_VALID) |-> resistance == '0, "resistance set outside a reported window")

  // Window end re-arms the drive
  `ARM_ASSERT(a_rearm, out_valid && window_done |-> current_code == CODE_MAX, "drive not re-armed at window end")

  // Reset leaves the block empty and ready
  `ARM_ASSERT_ANY(a_rst_clear, rst |=> !out_valid && in_ready, "not idle after reset")

endmodule

bind autoranging_resistance_meter arm_checker u_arm_checker (.*);

FILE: sim/testbench.sv
`timescale 1ns / 1ps

module testbench;
  import arm_pkg::*;

  // Sample styles for the stimulus generator
  localparam int SMP_ANY      = 0;  // uniform over the whole 12-bit range
  localparam int SMP_FIELD    = 1;  // mostly in range, some over and under
  localparam int SMP_EDGE     = 2;  // values on and next to the limits, at the range ends, or random
  localparam int SMP_INRANGE  = 3;  // strictly between the limits
  localparam int SMP_DESCEND  = 4;  // over-range early in the window, then in range

  // Reported ohms saturate to this span
  localparam longint OHMS_CEIL  = 4194303;
  localparam longint OHMS_FLOOR = -65535;

  // Cycles with no handshake at all before the run is declared hung
  localparam int STALL_LIMIT = 3000;
  // Quiet cycles after the last word; covers the longest window-closing tick
  localparam int TAIL_CYCLES = 100;
  // Length of the deliberate receiver hold-off
  localparam int LONG_HOLD = 300;

  // One result word as the block should present it
  typedef struct packed {
    logic [CODE_W-1:0]       code;
    logic                    done;
    status_t                 stat;
    logic signed [RES_W-1:0] ohms;
  } reading_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic              psel    = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite  = 1'b0;
  logic [ADDR_W-1:0] paddr   = '0;
  logic [DATA_W-1:0] pwdata  = '0;
  logic [DATA_W-1:0] prdata;
  logic              pready;

  logic                    in_valid   = 1'b0;
  logic                    in_ready;
  logic [SAMPLE_W-1:0]     adc_sample = '0;
  logic                    out_valid;
  logic                    out_ready  = 1'b0;
  logic [CODE_W-1:0]       current_code;
  logic                    window_done;
  logic [1:0]              status;
  logic signed [RES_W-1:0] resistance;

  // Shadow copy of the registers, loaded with their reset values
  logic [SAMPLE_W-1:0] cfg_high   = HIGH_LIMIT_RST;
  logic [SAMPLE_W-1:0] cfg_low    = LOW_LIMIT_RST;
  logic [OHMS_W-1:0]   cfg_offset = OFFSET_RST;
  logic [SCALE_W-1:0]  cfg_scale  = SCALE_RST;

  // Shadow copy of the measurement state
  logic [CODE_W-1:0] mdl_code  = CODE_MAX;
  int                mdl_ticks = 0;
  logic [SUM_W-1:0]  mdl_sum   = '0;
  logic [CNT_W-1:0]  mdl_count = '0;

  // Words predicted but not yet seen on the output
  reading_t readings_due[$];

  // Knobs for the sender and the receiver
  bit tx_gaps_on   = 1'b1;
  bit rx_stalls_on = 1'b1;
  int hold_cycles  = 0;
  int stall_left   = 0;

  int mismatches     = 0;
  int samples_sent   = 0;
  int words_checked  = 0;
  int windows_closed = 0;
  int ohms_reports   = 0;
  int valid_ticks    = 0;
  int over_ticks     = 0;
  int under_ticks    = 0;
  int reg_writes     = 0;
  int quiet_cycles   = 0;

  autoranging_resistance_meter i_dut (
    .clk          (clk),
    .rst          (rst),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .adc_sample   (adc_sample),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .current_code (current_code),
    .window_done  (window_done),
    .status       (status),
    .resistance   (resistance)
  );

  // 12 ns clock, 6 ns per half
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Print one line per mismatch and count every one
  task automatic report_mismatch(string msg);
    mismatches++;
    $display("[%0t] MISMATCH: %s", $realtime, msg);
  endtask

  // Average the window's quotients, scale to ohms, remove the offset, saturate
  function automatic logic signed [RES_W-1:0] averaged_ohms();
    logic [63:0] prod;
    logic [63:0] quo;
    longint      ohms;
    if (mdl_count == '0) return '0;
    prod = 64'(mdl_sum) * 64'(cfg_scale);
    quo  = (prod / 64'(mdl_count)) >> FRAC_W;
    if (quo > 64'(OHMS_CEIL - OHMS_FLOOR)) quo = 64'(OHMS_CEIL - OHMS_FLOOR);
    ohms = longint'(quo) - longint'(cfg_offset);
    if (ohms > OHMS_CEIL) ohms = OHMS_CEIL;
    if (ohms < OHMS_FLOOR) ohms = OHMS_FLOOR;
    return RES_W'(ohms);
  endfunction

  // Advance the shadow state by one tick and return the word it yields
  function automatic reading_t predict_reading(logic [SAMPLE_W-1:0] smp);
    reading_t          rd;
    logic [CODE_W-1:0] divisor;
    logic [SAMPLE_W-1:0] quo;
    logic [SUM_W:0]    acc;
    rd.done = 1'b0;
    rd.ohms = '0;
    // over-range is tested first, so it wins when the limits overlap
    if (smp >= cfg_high) begin
      rd.stat = ST_OVER;
      if (mdl_code > 1) mdl_code = mdl_code - 1'b1;
      else mdl_code = CODE_W'(1);
    end else if (smp <= cfg_low) begin
      rd.stat = ST_UNDER;
    end else begin
      rd.stat = ST_VALID;
      divisor = (mdl_code == '0) ? CODE_W'(1) : mdl_code;
      quo = smp / divisor;
      acc = {1'b0, mdl_sum} + (SUM_W + 1)'(quo);
      mdl_sum = (acc > {1'b0, SUM_MAX}) ? SUM_MAX : acc[SUM_W-1:0];
      if (mdl_count != CNT_MAX) mdl_count = mdl_count + 1'b1;
    end
    // window end overrides any step of the code
    if (mdl_ticks >= WINDOW_TICKS - 1) begin
      rd.done = 1'b1;
      if (rd.stat == ST_VALID) rd.ohms = averaged_ohms();
      mdl_code  = CODE_MAX;
      mdl_sum   = '0;
      mdl_count = '0;
      mdl_ticks = 0;
    end else begin
      mdl_ticks++;
    end
    rd.code = mdl_code;
    return rd;
  endfunction

  function automatic logic [SAMPLE_W-1:0] pick_sample(int style);
    int hi;
    int lo;
    int v;
    int roll;
    hi   = int'(cfg_high);
    lo   = int'(cfg_low);
    v    = $urandom_range(0, 4095);
    roll = $urandom_range(0, 99);
    case (style)
      SMP_FIELD: begin
        if (roll < 8) v = $urandom_range(hi, 4095);
        else if (roll < 16) v = $urandom_range(0, lo);
        else if (hi - lo >= 2) v = $urandom_range(lo + 1, hi - 1);
      end
      SMP_INRANGE: begin
        if (hi - lo >= 2) v = $urandom_range(lo + 1, hi - 1);
      end
      SMP_DESCEND: begin
        // walk the code far down so the quotients grow large
        if (mdl_ticks < 240) v = 4095;
        else if (hi - lo >= 2) v = $urandom_range(lo + 1, hi - 1);
      end
      SMP_EDGE: begin
        case ($urandom_range(0, 8))
          0: v = 0;
          1: v = 4095;
          2: v = hi;
          3: v = lo;
          4: v = lo + 1;
          5: v = hi - 1;
          6: v = hi + 1;
          7: v = lo - 1;
          default: ;
        endcase
      end
      default: ;
    endcase
    return SAMPLE_W'(v);
  endfunction

  function automatic logic [DATA_W-1:0] pick_reg_value();
    case ($urandom_range(0, 4))
      0: return '0;
      1: return '1;
      default: return DATA_W'($urandom);
    endcase
  endfunction

  // Offer one sample, wait for the handshake, record the expected word,
  // then maybe idle. With no gap, valid stays high for the next word.
  task automatic send_sample(logic [SAMPLE_W-1:0] smp);
    int gap;
    int roll;
    in_valid   <= 1'b1;
    adc_sample <= smp;
    do @(posedge clk); while (in_ready !== 1'b1);
    readings_due.push_back(predict_reading(smp));
    samples_sent++;
    gap = 0;
    if (tx_gaps_on) begin
      roll = $urandom_range(0, 99);
      if (roll >= 95) gap = $urandom_range(20, 60);
      else if (roll >= 60) gap = $urandom_range(1, 4);
    end
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Send a run of samples; the tick that closes a window is usually in range
  // so that it carries a resistance report
  task automatic run_samples(int count, int style);
    repeat (count) begin
      if (mdl_ticks == WINDOW_TICKS - 1 && $urandom_range(0, 99) < 85)
        send_sample(pick_sample(SMP_INRANGE));
      else
        send_sample(pick_sample(style));
    end
  endtask

  // Drop valid and hold until every predicted word has come out
  task automatic drain_readings();
    in_valid <= 1'b0;
    while (readings_due.size() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  task automatic apb_write(logic [1:0] idx, logic [DATA_W-1:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ADDR_W'({idx, 2'b00});
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (pready !== 1'b1);
    case (idx)
      REG_HIGH_LIMIT: cfg_high   = data[SAMPLE_W-1:0];
      REG_LOW_LIMIT:  cfg_low    = data[SAMPLE_W-1:0];
      REG_OFFSET:     cfg_offset = data[OHMS_W-1:0];
      REG_SCALE:      cfg_scale  = data[SCALE_W-1:0];
      default: ;
    endcase
    reg_writes++;
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  // Read a register and compare it with the shadow copy
  task automatic apb_read_check(logic [1:0] idx);
    logic [DATA_W-1:0] want;
    case (idx)
      REG_HIGH_LIMIT: want = DATA_W'(cfg_high);
      REG_LOW_LIMIT:  want = DATA_W'(cfg_low);
      REG_OFFSET:     want = DATA_W'(cfg_offset);
      REG_SCALE:      want = DATA_W'(cfg_scale);
      default:        want = '0;
    endcase
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= ADDR_W'({idx, 2'b00});
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (pready !== 1'b1);
    if (prdata !== want)
      report_mismatch($sformatf("register %0d read 0x%08h, expected 0x%08h",
                                idx, prdata, want));
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  // Defaults after reset, then write and read back every register
  task automatic test_register_access();
    apb_read_check(REG_HIGH_LIMIT);
    apb_read_check(REG_LOW_LIMIT);
    apb_read_check(REG_OFFSET);
    apb_read_check(REG_SCALE);
    apb_write(REG_HIGH_LIMIT, 32'hFFFF_F5A5);
    apb_write(REG_LOW_LIMIT, 32'h0000_0A5A);
    apb_write(REG_OFFSET, 32'h1234_A5C3);
    apb_write(REG_SCALE, 32'hC35A_96E1);
    apb_read_check(REG_HIGH_LIMIT);
    apb_read_check(REG_LOW_LIMIT);
    apb_read_check(REG_OFFSET);
    apb_read_check(REG_SCALE);
    // restore defaults for the measurement tests
    apb_write(REG_HIGH_LIMIT, DATA_W'(HIGH_LIMIT_RST));
    apb_write(REG_LOW_LIMIT, DATA_W'(LOW_LIMIT_RST));
    apb_write(REG_OFFSET, DATA_W'(OFFSET_RST));
    apb_write(REG_SCALE, DATA_W'(SCALE_RST));
  endtask

  // Field extremes and values right on the default limits
  task automatic test_sample_extremes();
    logic [SAMPLE_W-1:0] corner_samples [16];
    corner_samples = '{12'd0, 12'd1, 12'd1599, 12'd1600, 12'd4094, 12'd4095,
                       12'd2048, 12'hAAA, 12'h555, 12'd4095, 12'd1601, 12'd3000,
                       12'd4094, 12'h800, 12'h7FF, 12'd4095};
    foreach (corner_samples[k]) send_sample(corner_samples[k]);
  endtask

  // Stall the receiver for a long stretch while the sender keeps offering,
  // then pause the sender until every word is back
  task automatic test_output_backpressure();
    tx_gaps_on  = 1'b0;
    hold_cycles = LONG_HOLD;
    run_samples(24, SMP_FIELD);
    drain_readings();
    tx_gaps_on = 1'b1;
  endtask

  // Close the first window under default settings for a real report
  task automatic test_first_window_report();
    run_samples(WINDOW_TICKS - mdl_ticks, SMP_FIELD);
  endtask

  // Every tick over-range: code walks down, holds at 1, and snaps back
  // to full scale on the closing tick; no valid sample, so no report
  task automatic test_drive_code_floor();
    drain_readings();
    apb_write(REG_HIGH_LIMIT, '0);
    apb_write(REG_LOW_LIMIT, '0);
    run_samples(WINDOW_TICKS - mdl_ticks, SMP_ANY);
  endtask

  // Low limit above high limit: the over-range test must win
  task automatic test_overlapping_limits();
    drain_readings();
    apb_write(REG_HIGH_LIMIT, 32'd2000);
    apb_write(REG_LOW_LIMIT, 32'd3000);
    run_samples(100, SMP_EDGE);
    drain_readings();
    apb_write(REG_HIGH_LIMIT, 32'd4095);
    apb_write(REG_LOW_LIMIT, 32'd4095);
    run_samples(100, SMP_ANY);
  endtask

  // Largest scale, no offset, small code: the report must saturate high.
  // Run this stretch with no idling on either side.
  task automatic test_resistance_ceiling();
    drain_readings();
    apb_write(REG_HIGH_LIMIT, 32'd4095);
    apb_write(REG_LOW_LIMIT, '0);
    apb_write(REG_OFFSET, '0);
    apb_write(REG_SCALE, '1);
    tx_gaps_on   = 1'b0;
    rx_stalls_on = 1'b0;
    run_samples(WINDOW_TICKS - mdl_ticks, SMP_FIELD);
    run_samples(WINDOW_TICKS, SMP_DESCEND);
    tx_gaps_on   = 1'b1;
    rx_stalls_on = 1'b1;
  endtask

  // Zero scale and the largest offset: the report must hit the low bound
  task automatic test_resistance_floor();
    drain_readings();
    apb_write(REG_SCALE, '0);
    apb_write(REG_OFFSET, 32'hFFFF);
    run_samples(WINDOW_TICKS, SMP_FIELD);
  endtask

  // Random register settings, extremes included, each for a random stretch
  task automatic test_random_settings();
    int style;
    repeat (4) begin
      drain_readings();
      apb_write(REG_HIGH_LIMIT, pick_reg_value());
      apb_write(REG_LOW_LIMIT, pick_reg_value());
      apb_write(REG_OFFSET, pick_reg_value());
      apb_write(REG_SCALE, pick_reg_value());
      style = $urandom_range(SMP_ANY, SMP_EDGE);
      run_samples($urandom_range(70, 150), style);
    end
  endtask

  // Receiver: random short stalls, a few long ones, and a requested hold-off
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else if (hold_cycles > 0) begin
      out_ready <= 1'b0;
      hold_cycles--;
    end else if (stall_left > 0) begin
      out_ready <= 1'b0;
      stall_left--;
    end else if (rx_stalls_on && $urandom_range(0, 99) < 12) begin
      out_ready  <= 1'b0;
      stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(15, 60)
                                                : $urandom_range(0, 2);
    end else begin
      out_ready <= 1'b1;
    end
  end

  // Compare each accepted word with the oldest prediction
  always @(posedge clk) begin
    reading_t want;
    if (!rst && out_valid === 1'b1 && out_ready) begin
      words_checked++;
      if (readings_due.size() == 0) begin
        report_mismatch($sformatf("word %0d arrived with nothing expected", words_checked));
      end else begin
        want = readings_due.pop_front();
        if (current_code !== want.code)
          report_mismatch($sformatf("word %0d current_code %0d, expected %0d",
                                    words_checked, current_code, want.code));
        if (window_done !== want.done)
          report_mismatch($sformatf("word %0d window_done %0b, expected %0b",
                                    words_checked, window_done, want.done));
        if (status !== want.stat)
          report_mismatch($sformatf("word %0d status %0d, expected %0d",
                                    words_checked, status, want.stat));
        if (resistance !== want.ohms)
          report_mismatch($sformatf("word %0d resistance %0d, expected %0d",
                                    words_checked, resistance, $signed(want.ohms)));
        if (want.done) windows_closed++;
        if (want.done && want.stat == ST_VALID) ohms_reports++;
        case (want.stat)
          ST_VALID: valid_ticks++;
          ST_OVER:  over_ticks++;
          default:  under_ticks++;
        endcase
      end
    end
  end

  // Watchdog: end the run if no handshake happens for too long
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) || (psel && penable)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("[%0t] watchdog: no handshake for %0d cycles, %0d words outstanding",
               $realtime, quiet_cycles, readings_due.size());
      $display("Some tests failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_register_access();
    test_sample_extremes();
    test_output_backpressure();
    test_first_window_report();
    test_drive_code_floor();
    test_overlapping_limits();
    test_resistance_ceiling();
    test_resistance_floor();
    test_random_settings();

    // let the last words out, then watch for strays
    drain_readings();
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("Run covered %0d samples and %0d result words over %0d closed windows %s",
             samples_sent, words_checked, windows_closed,
             $sformatf("(%0d with a resistance report).", ohms_reports));
    $display("Tick classes seen: %0d in range, %0d over-range, %0d under-range; %s",
             valid_ticks, over_ticks, under_ticks,
             $sformatf("%0d register writes.", reg_writes));
    if (mismatches == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
